### sv/rvss_pkg.sv
// package: shared constants, opcode codes, decoded operation type and decoder
`timescale 1ns / 1ps
`default_nettype none

package rvss_pkg;

    // data memory geometry (power of two, split into four byte lanes)
    localparam int DATA_BYTES = 4096;
    localparam int DADDR_W    = $clog2(DATA_BYTES);
    localparam int DROWS      = DATA_BYTES / 4;
    localparam int DROW_W     = $clog2(DROWS);

    // register file geometry
    localparam int XLEN   = 32;
    localparam int NREGS  = 32;
    localparam int RIDX_W = $clog2(NREGS);

    // stream packing
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_PC_LSB  = 0;
    localparam int OUT_WR_BIT  = 32;
    localparam int OUT_IDX_LSB = 33;
    localparam int OUT_VAL_LSB = 38;
    localparam int OUT_NOP_BIT = 70;
    localparam int OUT_TDATA_W = 72;

    // major opcodes
    localparam logic [6:0] OPC_RTYPE  = 7'h33;
    localparam logic [6:0] OPC_ITYPE  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_LUI    = 7'h37;

    // funct3 / funct7 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRAI = 3'd5;
    localparam logic [2:0] F3_ORI  = 3'd6;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_SRA  = 7'h20;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ADD,
        OP_XOR,
        OP_SRAI,
        OP_ORI,
        OP_LB,
        OP_LW,
        OP_SB,
        OP_SW,
        OP_BEQ,
        OP_JAL,
        OP_LUI
    } op_t;

    // full decode; anything not exactly matched is a no-op
    function automatic op_t decode_op(input logic [31:0] ins);
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
        op_t        op;
        opc = ins[6:0];
        f3  = ins[14:12];
        f7  = ins[31:25];
        op  = OP_NOP;
        case (opc)
            OPC_RTYPE:
            begin
                if (f7 == F7_BASE && f3 == F3_ADD)
                    op = OP_ADD;
                else if (f7 == F7_BASE && f3 == F3_XOR)
                    op = OP_XOR;
            end
            OPC_ITYPE:
            begin
                if (f3 == F3_SRAI && f7 == F7_SRA)
                    op = OP_SRAI;
                else if (f3 == F3_ORI)
                    op = OP_ORI;
            end
            OPC_LOAD:
            begin
                if (f3 == F3_BYTE)
                    op = OP_LB;
                else if (f3 == F3_WORD)
                    op = OP_LW;
            end
            OPC_STORE:
            begin
                if (f3 == F3_BYTE)
                    op = OP_SB;
                else if (f3 == F3_WORD)
                    op = OP_SW;
            end
            OPC_BRANCH:
            begin
                if (f3 == F3_BEQ)
                    op = OP_BEQ;
            end
            OPC_JAL:
                op = OP_JAL;
            OPC_LUI:
                op = OP_LUI;
            default:
                op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

### sv/rvss_ram.sv
// generic simple dual-port ram, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module rvss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
    end

    // registered read, holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/riscv_subset_instruction_step.sv
// top level: pipelined rv32i subset execute unit with register file and data memory
//
// Usage: each item on the s_ channel is one 32-bit instruction word, the one
// fetched at the current pc. Each accepted item yields exactly one result item
// on the m_ channel: next pc, register write flag, index and value, no-op flag.
// The pc, the 32 registers and the byte-addressed data memory live inside.
// Stages: register read (registered as the instruction is accepted), then
// execute / data memory access, then the result stage, which offers the
// result item on the m_ channel.
// Throughput: one instruction per cycle unless stalled; loads, stores and dependent
// instructions run back to back through operand forwarding. The longest path is a
// load result forwarded into the next instruction's address adder.
// Reset: pc and registers read as zero at once; the data memory is zeroed by
// a clearing pass over its DATA_BYTES/4 rows (1024 at 4096 bytes), one row of four
// byte lanes a cycle, during which s_tready stays low.
// Stall: a result waiting on m_tready holds stable; one more instruction is
// still taken into the execute stage, after which s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module riscv_subset_instruction_step (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] instruction
    input  wire logic [rvss_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] next_pc, [32] reg_written, [37:33] reg_index, [69:38] reg_value,
    // [70] was_nop, [71] zero
    output logic      [rvss_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import rvss_pkg::*;

    // clearing pass state
    logic              clr_busy_reg;
    logic [DROW_W-1:0] clr_row_reg;

    // handshake and stage enables
    logic in_fire;
    logic out_fire;
    logic s2_free;
    logic s1_fire;

    // execute stage registers
    logic            s1_valid_reg;
    logic [XLEN-1:0] s1_ins_reg;
    logic            s1_v1_reg;
    logic            s1_v2_reg;

    // result stage registers
    logic              s2_valid_reg;
    logic [XLEN-1:0]   s2_pc_reg;
    logic              s2_wr_reg;
    logic [RIDX_W-1:0] s2_rd_reg;
    logic [XLEN-1:0]   s2_val_reg;
    logic              s2_nop_reg;
    logic              s2_lb_reg;
    logic              s2_lw_reg;
    logic [1:0]        s2_lane_reg;

    // architectural state outside the rams
    logic [XLEN-1:0]   pc_reg;
    logic [NREGS-1:0]  rv_valid_reg;
    logic              w_valid_reg;
    logic [RIDX_W-1:0] w_idx_reg;
    logic [XLEN-1:0]   w_val_reg;

    // register file ram ports
    logic            rf_we;
    logic [XLEN-1:0] rf_q1;
    logic [XLEN-1:0] rf_q2;

    // execute stage logic
    op_t               s1_op;
    logic [RIDX_W-1:0] s1_rd;
    logic [RIDX_W-1:0] s1_rs1;
    logic [RIDX_W-1:0] s1_rs2;
    logic [XLEN-1:0]   opa;
    logic [XLEN-1:0]   opb;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_s;
    logic [XLEN-1:0]   imm_b;
    logic [XLEN-1:0]   imm_j;
    logic [XLEN-1:0]   mem_addr;
    logic [DROW_W-1:0] row_base;
    logic [XLEN-1:0]   ex_val;
    logic [XLEN-1:0]   ex_next;
    logic              ex_wr;
    logic              ex_nop;
    logic              is_load;

    // data memory lane ports
    logic [1:0]        lane_k    [4];
    logic [DROW_W-1:0] lane_row  [4];
    logic [7:0]        lane_wdata[4];
    logic [3:0]        lane_we;
    logic [7:0]        lane_q    [4];

    // result stage logic
    logic [XLEN-1:0] ld_word;
    logic [XLEN-1:0] s2_value;

    // handshakes: the result stage frees as soon as its item is taken
    assign out_fire = s2_valid_reg && m_tready;
    assign s2_free  = !s2_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || s2_free);
    assign in_fire  = s_tvalid && s_tready;

    // clearing pass over the data memory rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_row_reg <= clr_row_reg + DROW_W'(1);
            if (clr_row_reg == DROW_W'(DROWS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // register file: two copies give two read ports
    assign rf_we = out_fire && s2_wr_reg;

    rvss_ram #(
        .WIDTH (XLEN),
        .DEPTH (NREGS)
    ) u_rf_a (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (s2_rd_reg),
        .wr_data (s2_value),
        .rd_en   (in_fire),
        .rd_addr (s_tdata[19:15]),
        .rd_data (rf_q1)
    );

    rvss_ram #(
        .WIDTH (XLEN),
        .DEPTH (NREGS)
    ) u_rf_b (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (s2_rd_reg),
        .wr_data (s2_value),
        .rd_en   (in_fire),
        .rd_addr (s_tdata[24:20]),
        .rd_data (rf_q2)
    );

    // register valid bits and last-write bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_valid_reg <= '0;
            w_valid_reg  <= 1'b0;
        end
        else if (rf_we)
        begin
            rv_valid_reg[s2_rd_reg] <= 1'b1;
            w_valid_reg             <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            w_idx_reg <= s2_rd_reg;
            w_val_reg <= s2_value;
        end
    end

    // execute stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // execute stage payload, valid bits sampled with the ram read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ins_reg <= s_tdata;
            s1_v1_reg  <= rv_valid_reg[s_tdata[19:15]];
            s1_v2_reg  <= rv_valid_reg[s_tdata[24:20]];
        end
    end

    // decode and immediates
    assign s1_op  = decode_op(s1_ins_reg);
    assign s1_rd  = s1_ins_reg[11:7];
    assign s1_rs1 = s1_ins_reg[19:15];
    assign s1_rs2 = s1_ins_reg[24:20];
    assign imm_i  = {{20{s1_ins_reg[31]}}, s1_ins_reg[31:20]};
    assign imm_s  = {{20{s1_ins_reg[31]}}, s1_ins_reg[31:25], s1_ins_reg[11:7]};
    assign imm_b  = {{19{s1_ins_reg[31]}}, s1_ins_reg[31], s1_ins_reg[7],
                     s1_ins_reg[30:25], s1_ins_reg[11:8], 1'b0};
    assign imm_j  = {{11{s1_ins_reg[31]}}, s1_ins_reg[31], s1_ins_reg[19:12],
                     s1_ins_reg[20], s1_ins_reg[30:21], 1'b0};

    // operand forwarding: result stage, then last write, then ram
    always_comb
    begin
        if (s2_valid_reg && s2_wr_reg && s2_rd_reg == s1_rs1)
            opa = s2_value;
        else if (w_valid_reg && w_idx_reg == s1_rs1)
            opa = w_val_reg;
        else if (s1_v1_reg)
            opa = rf_q1;
        else
            opa = '0;

        if (s2_valid_reg && s2_wr_reg && s2_rd_reg == s1_rs2)
            opb = s2_value;
        else if (w_valid_reg && w_idx_reg == s1_rs2)
            opb = w_val_reg;
        else if (s1_v2_reg)
            opb = rf_q2;
        else
            opb = '0;
    end

    // data address, wraps within the memory
    assign is_load  = (s1_op == OP_LB) || (s1_op == OP_LW);
    assign mem_addr = opa + (((s1_op == OP_SB) || (s1_op == OP_SW)) ? imm_s : imm_i);
    assign row_base = mem_addr[DADDR_W-1:2];

    // alu and next pc
    always_comb
    begin
        ex_val  = '0;
        ex_next = pc_reg + XLEN'(4);
        ex_wr   = 1'b0;
        ex_nop  = 1'b0;
        case (s1_op)
            OP_ADD:
            begin
                ex_val = opa + opb;
                ex_wr  = 1'b1;
            end
            OP_XOR:
            begin
                ex_val = opa ^ opb;
                ex_wr  = 1'b1;
            end
            OP_SRAI:
            begin
                ex_val = XLEN'($signed(opa) >>> s1_ins_reg[24:20]);
                ex_wr  = 1'b1;
            end
            OP_ORI:
            begin
                ex_val = opa | imm_i;
                ex_wr  = 1'b1;
            end
            OP_LB, OP_LW:
                ex_wr = 1'b1;
            OP_SB, OP_SW:
                ex_wr = 1'b0;
            OP_BEQ:
            begin
                if (opa == opb)
                    ex_next = pc_reg + imm_b;
            end
            OP_JAL:
            begin
                ex_val  = pc_reg + XLEN'(4);
                ex_wr   = 1'b1;
                ex_next = pc_reg + imm_j;
            end
            OP_LUI:
            begin
                ex_val = {s1_ins_reg[31:12], 12'h000};
                ex_wr  = 1'b1;
            end
            default:
                ex_nop = 1'b1;
        endcase
        if (s1_rd == '0)
            ex_wr = 1'b0;
    end

    // byte lane addressing: lane j holds byte k of the access
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            lane_k[j] = 2'(j) - mem_addr[1:0];
            if (clr_busy_reg)
            begin
                lane_row[j]   = clr_row_reg;
                lane_wdata[j] = '0;
                lane_we[j]    = 1'b1;
            end
            else
            begin
                lane_row[j]   = (2'(j) >= mem_addr[1:0]) ? row_base
                                                          : row_base + DROW_W'(1);
                lane_wdata[j] = opb[{lane_k[j], 3'b000} +: 8];
                lane_we[j]    = s1_fire && ((s1_op == OP_SW) ||
                                ((s1_op == OP_SB) && (lane_k[j] == 2'd0)));
            end
        end
    end

    // data memory as four byte lanes
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        rvss_ram #(
            .WIDTH (8),
            .DEPTH (DROWS)
        ) u_lane (
            .clk     (clk),
            .wr_en   (lane_we[g]),
            .wr_addr (lane_row[g]),
            .wr_data (lane_wdata[g]),
            .rd_en   (s1_fire && is_load),
            .rd_addr (lane_row[g]),
            .rd_data (lane_q[g])
        );
    end

    // pc advances as each instruction leaves execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= '0;
        else if (s1_fire)
            pc_reg <= ex_next;
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_fire)
            s2_valid_reg <= 1'b1;
        else if (out_fire)
            s2_valid_reg <= 1'b0;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_pc_reg   <= ex_next;
            s2_wr_reg   <= ex_wr;
            s2_rd_reg   <= ex_wr ? s1_rd : '0;
            s2_val_reg  <= ex_val;
            s2_nop_reg  <= ex_nop;
            s2_lb_reg   <= (s1_op == OP_LB);
            s2_lw_reg   <= (s1_op == OP_LW);
            s2_lane_reg <= mem_addr[1:0];
        end
    end

    // load data assembly from the lanes
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            ld_word[8*k +: 8] = lane_q[s2_lane_reg + 2'(k)];
    end

    always_comb
    begin
        if (s2_lb_reg)
            s2_value = {{24{lane_q[s2_lane_reg][7]}}, lane_q[s2_lane_reg]};
        else if (s2_lw_reg)
            s2_value = ld_word;
        else
            s2_value = s2_val_reg;
    end

    // result item
    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {1'b0, s2_nop_reg, (s2_wr_reg ? s2_value : XLEN'(0)),
                       s2_rd_reg, s2_wr_reg, s2_pc_reg};

endmodule

`default_nettype wire

### sv/rvss_checker.sv
// checker on the top level ports, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rvss_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [rvss_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import rvss_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no register write means index and value read zero
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OUT_WR_BIT] |->
            m_tdata[OUT_NOP_BIT-1:OUT_IDX_LSB] == '0)
        else $error("index or value set without a register write");

    // writes never target x0
    a_write_not_x0: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_WR_BIT] |->
            m_tdata[OUT_VAL_LSB-1:OUT_IDX_LSB] != '0)
        else $error("register write to x0 reported");

    // a no-op writes nothing
    a_nop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_NOP_BIT] |-> !m_tdata[OUT_WR_BIT])
        else $error("no-op reported a register write");

    // padding bit stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[OUT_TDATA_W-1])
        else $error("padding bit set");

endmodule

bind riscv_subset_instruction_step rvss_checker u_rvss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
